// ===== rtl/core/sot_pkg.sv =====
`timescale 1ns / 1ps
package sot_pkg;

  localparam int DEFAULT_MAX_SECTIONS = 16;

  // request kinds on the input tuser
  localparam logic [1:0] REQ_LOAD     = 2'd0;
  localparam logic [1:0] REQ_IMG2FILE = 2'd1;
  localparam logic [1:0] REQ_FILE2IMG = 2'd2;
  localparam logic [1:0] REQ_NONE     = 2'd3;

  // result kinds on the output tuser
  localparam logic [1:0] KIND_PASS = 2'd0;
  localparam logic [1:0] KIND_HIT  = 2'd1;
  localparam logic [1:0] KIND_MISS = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_HEADER_SIZE       = 2'd0;
  localparam logic [1:0] REG_FILE_ALIGNMENT    = 2'd1;
  localparam logic [1:0] REG_SECTION_ALIGNMENT = 2'd2;
  localparam logic [1:0] REG_SECTION_COUNT     = 2'd3;

  localparam logic [31:0] RST_HEADER_SIZE       = 32'd0;
  localparam logic [31:0] RST_FILE_ALIGNMENT    = 32'd512;
  localparam logic [31:0] RST_SECTION_ALIGNMENT = 32'd4096;
  localparam logic [4:0]  RST_SECTION_COUNT     = 5'd0;

  typedef struct packed {
    logic [31:0] raw_length;
    logic [31:0] raw_start;
    logic [31:0] virt_length;
    logic [31:0] virt_start;
  } desc_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] mapped;
  } range_res_t;

endpackage

// ===== rtl/core/section_offset_translator.sv =====
`timescale 1ns / 1ps
// load beat: accepted while idle, no result beat
// query beat: accepted while idle, then one descriptor per cycle from the descriptor ram
// through the single range unit (up to min(section_count, MAX_SECTIONS) descriptors),
// then into the output register; pass-through and empty table skip the scan
// the next beat is accepted once the result sits in the output register
// rst clears control state, output valid and configuration registers to reset values; descriptors are not cleared
module section_offset_translator #(
  parameter int MAX_SECTIONS = sot_pkg::DEFAULT_MAX_SECTIONS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // entry_index[3:0], virt_start[35:4], virt_length[67:36], raw_start[99:68],
  // raw_length[131:100], query_offset[163:132], zero fill
  input  logic [167:0] s_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // mapped_offset[31:0], hit_index[35:32], zero fill
  output logic [39:0]  m_tdata,
  // match_kind[1:0]
  output logic [1:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [31:0] header_size;
  logic [31:0] file_alignment;
  logic [31:0] section_alignment;
  logic [4:0]  section_count;

  logic [1:0]       state;
  logic             img2file;
  logic [31:0]      offset;
  logic [IDX_W-1:0] idx;
  logic [31:0]      res_mapped;
  logic [1:0]       res_kind;
  logic [3:0]       res_hit;

  logic [1:0]  in_req;
  logic [3:0]  in_entry;
  logic [31:0] in_offset;
  logic        in_fire;
  logic        pass_thru;
  logic [31:0] cnt_lim;
  logic        scan_last;
  logic        slot_ok;
  logic [31:0] idx_ext;

  logic [IDX_W-1:0]    raddr;
  logic [IDX_W-1:0]    waddr;
  sot_pkg::desc_t      wdesc;
  sot_pkg::desc_t      rdesc;
  sot_pkg::range_res_t rres;

  assign in_req    = s_tuser;
  assign in_entry  = s_tdata[3:0];
  assign in_offset = s_tdata[163:132];
  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;

  assign wdesc.virt_start  = s_tdata[35:4];
  assign wdesc.virt_length = s_tdata[67:36];
  assign wdesc.raw_start   = s_tdata[99:68];
  assign wdesc.raw_length  = s_tdata[131:100];

  assign slot_ok = ({28'd0, in_entry} < 32'(MAX_SECTIONS));
  assign waddr   = IDX_W'({28'd0, in_entry});

  assign pass_thru = (in_offset < header_size) || (file_alignment == section_alignment);
  assign cnt_lim   = ({27'd0, section_count} > 32'(MAX_SECTIONS)) ?
                     32'(MAX_SECTIONS) : {27'd0, section_count};
  assign idx_ext   = 32'(idx);
  assign scan_last = (idx_ext + 32'd1) >= cnt_lim;

  // prefetch next descriptor so one is checked every cycle
  assign raddr = (state == ST_SCAN) ? idx + IDX_W'(1) : '0;

  sot_ram #(
    .WIDTH ($bits(sot_pkg::desc_t)),
    .DEPTH (MAX_SECTIONS)
  ) u_desc_ram (
    .clk   (clk),
    .we    (in_fire && (in_req == sot_pkg::REQ_LOAD) && slot_ok),
    .waddr (waddr),
    .wdata (wdesc),
    .raddr (raddr),
    .rdata (rdesc)
  );

  sot_range_unit u_range (
    .desc     (rdesc),
    .img2file (img2file),
    .offset   (offset),
    .res      (rres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      header_size       <= sot_pkg::RST_HEADER_SIZE;
      file_alignment    <= sot_pkg::RST_FILE_ALIGNMENT;
      section_alignment <= sot_pkg::RST_SECTION_ALIGNMENT;
      section_count     <= sot_pkg::RST_SECTION_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        sot_pkg::REG_HEADER_SIZE:       header_size       <= cfg_data;
        sot_pkg::REG_FILE_ALIGNMENT:    file_alignment    <= cfg_data;
        sot_pkg::REG_SECTION_ALIGNMENT: section_alignment <= cfg_data;
        sot_pkg::REG_SECTION_COUNT:     section_count     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire && (in_req == sot_pkg::REQ_IMG2FILE ||
                          in_req == sot_pkg::REQ_FILE2IMG)) begin
            if (pass_thru || cnt_lim == 32'd0) begin
              state <= ST_DONE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rres.hit || scan_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        img2file <= (in_req == sot_pkg::REQ_IMG2FILE);
        offset   <= in_offset;
        idx      <= '0;
        if (pass_thru) begin
          res_mapped <= in_offset;
          res_kind   <= sot_pkg::KIND_PASS;
        end else begin
          res_mapped <= 32'd0;
          res_kind   <= sot_pkg::KIND_MISS;
        end
        res_hit <= 4'd0;
      end
      ST_SCAN: begin
        idx <= idx + IDX_W'(1);
        if (rres.hit) begin
          res_mapped <= rres.mapped;
          res_kind   <= sot_pkg::KIND_HIT;
          res_hit    <= idx_ext[3:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {4'd0, res_hit, res_mapped};
      m_tuser <= res_kind;
    end
  end

endmodule

// ===== rtl/core/sot_ram.sv =====
`timescale 1ns / 1ps
module sot_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sot_range_unit.sv =====
`timescale 1ns / 1ps
module sot_range_unit (
  input  sot_pkg::desc_t      desc,
  input  logic                img2file,
  input  logic [31:0]         offset,
  output sot_pkg::range_res_t res
);

  logic [31:0] from_start;
  logic [31:0] from_len;
  logic [31:0] to_start;
  logic [31:0] range_end;

  always_comb begin
    if (img2file) begin
      from_start = desc.virt_start;
      from_len   = desc.virt_length;
      to_start   = desc.raw_start;
    end else begin
      from_start = desc.raw_start;
      from_len   = desc.raw_length;
      to_start   = desc.virt_start;
    end
    // end of range wraps mod 2^32
    range_end  = from_start + from_len;
    res.hit    = (offset >= from_start) && (offset < range_end);
    res.mapped = to_start + (offset - from_start);
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int NSECT = sot_pkg::DEFAULT_MAX_SECTIONS;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 24;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  entry_index;
    logic [31:0] virt_start;
    logic [31:0] virt_length;
    logic [31:0] raw_start;
    logic [31:0] raw_length;
    logic [31:0] query_offset;
  } sot_req_t;

  typedef struct packed {
    logic [31:0] mapped;
    logic [1:0]  kind;
    logic [3:0]  idx;
  } xlat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [167:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  section_offset_translator uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // translator state as the block should hold it
  logic [31:0] hdr_size = sot_pkg::RST_HEADER_SIZE;
  logic [31:0] file_align = sot_pkg::RST_FILE_ALIGNMENT;
  logic [31:0] sect_align = sot_pkg::RST_SECTION_ALIGNMENT;
  logic [4:0]  sect_count = sot_pkg::RST_SECTION_COUNT;
  logic [31:0] sect_virt_start [NSECT];
  logic [31:0] sect_virt_length [NSECT];
  logic [31:0] sect_raw_start [NSECT];
  logic [31:0] sect_raw_length [NSECT];

  // table as queued, used only to aim query offsets at sections
  logic [31:0] plan_virt_start [NSECT];
  logic [31:0] plan_virt_length [NSECT];
  logic [31:0] plan_raw_start [NSECT];
  logic [31:0] plan_raw_length [NSECT];

  sot_req_t pending_reqs[$];
  xlat_t    expected_xlats[$];
  int       errors = 0;
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;
  int       hold_requests = 0;

  task automatic translate_request(input sot_req_t r);
    xlat_t       res;
    logic [31:0] from_s, from_e, to_s;
    int          n;
    bit          found;
    case (r.req_type)
      sot_pkg::REQ_LOAD: begin
        sect_virt_start[r.entry_index] = r.virt_start;
        sect_virt_length[r.entry_index] = r.virt_length;
        sect_raw_start[r.entry_index] = r.raw_start;
        sect_raw_length[r.entry_index] = r.raw_length;
      end
      sot_pkg::REQ_IMG2FILE, sot_pkg::REQ_FILE2IMG: begin
        if (r.query_offset < hdr_size || file_align == sect_align) begin
          res = '{mapped: r.query_offset, kind: sot_pkg::KIND_PASS, idx: 4'd0};
        end else begin
          res = '{mapped: 32'd0, kind: sot_pkg::KIND_MISS, idx: 4'd0};
          found = 1'b0;
          n = (sect_count > NSECT) ? NSECT : int'(sect_count);
          for (int i = 0; i < n; i++) begin
            if (!found) begin
              if (r.req_type == sot_pkg::REQ_IMG2FILE) begin
                from_s = sect_virt_start[i];
                from_e = sect_virt_start[i] + sect_virt_length[i];
                to_s = sect_raw_start[i];
              end else begin
                from_s = sect_raw_start[i];
                from_e = sect_raw_start[i] + sect_raw_length[i];
                to_s = sect_virt_start[i];
              end
              if (r.query_offset >= from_s && r.query_offset < from_e) begin
                found = 1'b1;
                res = '{mapped: to_s + (r.query_offset - from_s), kind: sot_pkg::KIND_HIT,
                        idx: i[3:0]};
              end
            end
          end
        end
        expected_xlats.push_back(res);
      end
      default: ;
    endcase
  endtask

  // driver: one beat offered at a time, held until taken
  always @(posedge clk) begin : drive_blk
    sot_req_t offered;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) translate_request(offered);
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          offered = pending_reqs.pop_front();
          s_tdata <= {4'd0, offered.query_offset, offered.raw_length, offered.raw_start,
                      offered.virt_length, offered.virt_start, offered.entry_index};
          s_tuser <= offered.req_type;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat, drives ready with random gaps and long holds
  always @(posedge clk) begin : mon_blk
    xlat_t want;
    int    hold_left;
    int    holds_served;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
      holds_served = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_xlats.size() == 0) begin
          $error("result beat with nothing expected: mapped_offset %h", m_tdata[31:0]);
          errors++;
        end else begin
          want = expected_xlats.pop_front();
          if (m_tdata[31:0] !== want.mapped) begin
            $error("mapped_offset: expected %h, got %h", want.mapped, m_tdata[31:0]);
            errors++;
          end
          if (m_tuser !== want.kind) begin
            $error("match_kind: expected %0d, got %0d", want.kind, m_tuser);
            errors++;
          end
          if (m_tdata[35:32] !== want.idx) begin
            $error("hit_index: expected %0d, got %0d", want.idx, m_tdata[35:32]);
            errors++;
          end
        end
      end
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin : dog_blk
    int quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sot_pkg::REG_HEADER_SIZE:       hdr_size = val;
      sot_pkg::REG_FILE_ALIGNMENT:    file_align = val;
      sot_pkg::REG_SECTION_ALIGNMENT: sect_align = val;
      sot_pkg::REG_SECTION_COUNT:     sect_count = val[4:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] hdr, input logic [31:0] fa,
                           input logic [31:0] sa, input logic [4:0] cnt);
    write_reg(sot_pkg::REG_HEADER_SIZE, hdr);
    write_reg(sot_pkg::REG_FILE_ALIGNMENT, fa);
    write_reg(sot_pkg::REG_SECTION_ALIGNMENT, sa);
    write_reg(sot_pkg::REG_SECTION_COUNT, {27'd0, cnt});
  endtask

  // wait until every beat is taken and every result is back
  task automatic drain;
    @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_xlats.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic push_req(input logic [1:0] kind, input logic [3:0] slot,
                          input logic [31:0] vs, input logic [31:0] vl,
                          input logic [31:0] rs, input logic [31:0] rl,
                          input logic [31:0] off);
    if (kind == sot_pkg::REQ_LOAD) begin
      plan_virt_start[slot] = vs;
      plan_virt_length[slot] = vl;
      plan_raw_start[slot] = rs;
      plan_raw_length[slot] = rl;
    end
    pending_reqs.push_back('{req_type: kind, entry_index: slot, virt_start: vs,
                             virt_length: vl, raw_start: rs, raw_length: rl,
                             query_offset: off});
  endtask

  task automatic queue_random(input int n);
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [31:0] vs, vl, rs, rl, off, from_s, from_l;
    int          pick;
    repeat (n) begin
      slot = $urandom_range(15);
      vs = $urandom;
      vl = $urandom;
      rs = $urandom;
      rl = $urandom;
      off = $urandom;
      pick = $urandom_range(99);
      if (pick < 12) begin
        kind = sot_pkg::REQ_LOAD;
        if ($urandom_range(4) != 0) begin
          vs = $urandom_range(63) << 12;
          vl = $urandom_range(32'h3000);
          rs = $urandom_range(63) << 9;
          rl = $urandom_range(32'h3000);
        end
      end else if (pick < 15) begin
        kind = sot_pkg::REQ_NONE;
      end else begin
        kind = $urandom_range(1) ? sot_pkg::REQ_IMG2FILE : sot_pkg::REQ_FILE2IMG;
        from_s = (kind == sot_pkg::REQ_IMG2FILE) ? plan_virt_start[slot] :
                 plan_raw_start[slot];
        from_l = (kind == sot_pkg::REQ_IMG2FILE) ? plan_virt_length[slot] :
                 plan_raw_length[slot];
        pick = $urandom_range(99);
        if (pick < 50)
          off = from_s + ((from_l == 0) ? 32'd0 : $urandom_range(from_l - 1));
        else if (pick < 60)
          off = from_s;
        else if (pick < 70)
          off = from_s + from_l - 1;
        else if (pick < 80)
          off = from_s + from_l;
        else if (pick < 90)
          off = hdr_size - $urandom_range(2);
      end
      push_req(kind, slot, vs, vl, rs, rl, off);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 28;
    snk_idle_pct = 69;
    configure(32'h400, 32'd512, 32'd4096, 5'd16);
    @(negedge clk);
    // fill every slot before any search can read one
    push_req(sot_pkg::REQ_LOAD, 4'd0, 32'h1000, 32'h0, 32'h400, 32'h0, 32'h0);
    push_req(sot_pkg::REQ_LOAD, 4'd1, 32'h1000, 32'h2000, 32'h400, 32'h1800, 32'hFFFFFFFF);
    push_req(sot_pkg::REQ_LOAD, 4'd2, 32'h2000, 32'h3000, 32'h2000, 32'h2000, 32'h0);
    push_req(sot_pkg::REQ_LOAD, 4'd3, 32'hFFFFF000, 32'h2000, 32'hFFFFFE00, 32'h400,
             32'h0);
    for (int i = 4; i < 15; i++)
      push_req(sot_pkg::REQ_LOAD, i[3:0], 32'h10000 + i * 32'h1000, 32'h800,
               32'h8000 + i * 32'h400, 32'h400, 32'h0);
    push_req(sot_pkg::REQ_LOAD, 4'd15, 32'h0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0);
    // below header, at header, zero length slot, overlap, wrapped range, top offset
    push_req(sot_pkg::REQ_IMG2FILE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h3FF);
    push_req(sot_pkg::REQ_IMG2FILE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h400);
    push_req(sot_pkg::REQ_IMG2FILE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1000);
    push_req(sot_pkg::REQ_IMG2FILE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h2800);
    push_req(sot_pkg::REQ_IMG2FILE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFFF800);
    push_req(sot_pkg::REQ_IMG2FILE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF);
    push_req(sot_pkg::REQ_FILE2IMG, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h500);
    push_req(sot_pkg::REQ_FILE2IMG, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF);
    push_req(sot_pkg::REQ_NONE, 4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
             32'hFFFFFFFF, 32'hFFFFFFFF);
    push_req(sot_pkg::REQ_FILE2IMG, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    drain();

    configure(32'h0, 32'd512, 32'd4096, 5'd16);
    queue_random(230);
    drain();
    configure(32'h1000, 32'h200, 32'h1000, 5'd5);
    queue_random(230);
    drain();

    src_idle_pct = 69;
    snk_idle_pct = 28;
    // equal alignments: identity, count past the table size
    configure(32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'd31);
    queue_random(200);
    drain();
    configure(32'hFFFFFFFF, 32'h0, 32'h1, 5'd0);
    queue_random(150);
    drain();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    configure(32'h200, 32'h200, 32'h1000, 5'd16);
    queue_random(250);
    // hold results back while beats are still queued
    hold_requests = hold_requests + 1;
    drain();
    configure(32'h0, 32'h1000, 32'h200, 5'd17);
    queue_random(250);
    drain();

    if (expected_xlats.size() != 0) begin
      $error("%0d results never arrived", expected_xlats.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
